[src/cpcc_pkg.sv]
// ----------------------------------------------------------------------------
// cpcc_pkg: shared types and constants of the color pair contrast checker
// Payload structs, fixed-point widths, luminance weights and the sRGB
// linearization lookup built at elaboration.
// ----------------------------------------------------------------------------
package cpcc_pkg;

   // Fixed-point formats
   localparam int LUMA_FRAC_BITS  = 16;
   localparam int RATIO_FRAC_BITS = 8;
   localparam int COLOR_W         = 8;
   localparam int LUMA_W          = LUMA_FRAC_BITS + 1;
   localparam int RATIO_W         = 13;
   localparam int CFG_W           = 13;
   localparam int LUT_DEPTH       = 2 ** COLOR_W;

   localparam logic [CFG_W-1:0]   MIN_CONTRAST_RESET = 13'd1152;
   localparam logic [RATIO_W-1:0] RATIO_MAX          = '1;
   localparam logic [RATIO_W-1:0] RATIO_ONE          = RATIO_W'(2 ** RATIO_FRAC_BITS);

   // Luminance weights in units of 1/10000
   localparam int WEIGHT_W   = 13;
   localparam int LUMA_SCALE = 10000;
   localparam logic [2:0][WEIGHT_W-1:0] CHANNEL_WEIGHT = {13'd722, 13'd7152, 13'd2126};

   localparam int PROD_W = LUMA_W + WEIGHT_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int SUM_W  = 30;
   localparam logic [SUM_W-1:0] SUM_ROUND = SUM_W'(LUMA_SCALE / 2);

   // Floor division by the weight scale through a reciprocal multiply
   localparam int RECIP_SHIFT  = 43;
   localparam int RECIP_W      = 30;
   localparam int RECIP_PROD_W = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << RECIP_SHIFT) + 64'(LUMA_SCALE - 1)) / 64'(LUMA_SCALE);
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_WIDE[RECIP_W-1:0];

   // The 0.05 flare offset
   localparam logic [LUMA_W-1:0] LUMA_OFFSET =
      LUMA_W'(((5 * (2 ** LUMA_FRAC_BITS)) + 50) / 100);

   // Ratio divider geometry
   localparam int QUOT_W     = 14;
   localparam int DIVIDEND_W = LUMA_W + RATIO_FRAC_BITS + 1;
   localparam int TRIAL_W    = LUMA_W + QUOT_W;

   // Linearization constants
   localparam int SEG_LIMIT   = 10;
   localparam int SEG_MUL     = 20;
   localparam int SEG_ROUND   = 32946;
   localparam int SEG_DIV     = 65892;
   localparam int GAMMA_SCALE = 1000;
   localparam int GAMMA_BIAS  = 14025;
   localparam int GAMMA_DIV   = 269025;
   localparam int CODE_MAX    = 255;

   typedef struct packed {
      logic [COLOR_W-1:0] text_red;
      logic [COLOR_W-1:0] text_green;
      logic [COLOR_W-1:0] text_blue;
      logic [COLOR_W-1:0] back_red;
      logic [COLOR_W-1:0] back_green;
      logic [COLOR_W-1:0] back_blue;
   } req_payload_type;

   typedef struct packed {
      logic [RATIO_W-1:0] contrast_ratio;
      logic               accessible;
      logic [LUMA_W-1:0]  text_luminance;
      logic [LUMA_W-1:0]  back_luminance;
   } rsp_payload_type;

   // One classified request between front end and divider
   typedef struct packed {
      logic [LUMA_W-1:0] text_luma;
      logic [LUMA_W-1:0] back_luma;
      logic [LUMA_W-1:0] bright;
      logic [LUMA_W-1:0] dark;
   } luma_pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef logic [LUT_DEPTH-1:0][LUMA_W-1:0] lin_lut_type;

   // Truncating Q0.32 product
   function automatic logic [63:0] qmul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return prod >> 32;
   endfunction

   function automatic logic [31:0] pow5_q32(input logic [31:0] w);
      logic [63:0] p2;
      logic [63:0] p4;
      logic [63:0] p5;
      p2 = qmul32(w, w);
      p4 = qmul32(p2[31:0], p2[31:0]);
      p5 = qmul32(p4[31:0], w);
      return p5[31:0];
   endfunction

   // One sRGB code to linear light: linear toe, else the 2.4 power
   function automatic logic [LUMA_W-1:0] lin_entry(input int code);
      logic [63:0] one;
      logic [63:0] num;
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] x;
      logic [31:0] w;
      logic [31:0] cand;
      one = 64'd1 << LUMA_FRAC_BITS;
      if (code <= SEG_LIMIT) begin
         return LUMA_W'((64'(code) * one * 64'(SEG_MUL) + 64'(SEG_ROUND)) / 64'(SEG_DIV));
      end
      if (code >= CODE_MAX) begin
         return LUMA_W'(one);
      end
      num = (64'(code) * 64'(GAMMA_SCALE) + 64'(GAMMA_BIAS)) << 32;
      t   = num / 64'(GAMMA_DIV);
      u   = qmul32(t[31:0], t[31:0]);
      w   = '0;
      // Fifth root by bit-wise search: u^(1/5) gives the extra 0.4 power
      for (int bit_idx = 31; bit_idx >= 0; bit_idx--) begin
         cand = w | (32'd1 << bit_idx);
         if (pow5_q32(cand) <= u[31:0]) begin
            w = cand;
         end
      end
      x = qmul32(u[31:0], w) + (64'd1 << (31 - LUMA_FRAC_BITS));
      return LUMA_W'(x >> (32 - LUMA_FRAC_BITS));
   endfunction

   function automatic lin_lut_type build_lin_lut();
      lin_lut_type lut;
      for (int code = 0; code < LUT_DEPTH; code++) begin
         lut[code] = lin_entry(code);
      end
      return lut;
   endfunction

   localparam lin_lut_type LIN_LUT = build_lin_lut();

endpackage

[src/color_pair_contrast_checker_unit.sv]
// ----------------------------------------------------------------------------
// color_pair_contrast_checker_unit: contrast ratio of a text/background pair
//
// A request (text and background color, 8-bit sRGB each) is taken at a
// rising edge with start high and busy low. One result follows per request,
// in order: rsp_strobe is high for one cycle with the contrast ratio
// (eight fraction bits, 1.0 to 21.0), the accessible flag and both
// luminances in Q1.16. One request per clock is sustained: the front end is a
// six-stage pipeline and the divider retires one quotient bit per stage over
// 14 stages. busy rises only when the queue between front end and divider is
// full; the divider drains it every cycle, so busy stays low. Results cannot
// be held off by the receiver. The threshold is written through
// csr_write_enable and csr_write_data; the user must do so only while idle,
// as the block itself does not enforce it. Reset drops any requests in
// flight and restores the threshold to 4.5.
// ----------------------------------------------------------------------------
module color_pair_contrast_checker_unit
   import cpcc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_payload_type  req_payload,
   output logic             rsp_strobe,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_write_enable,
   input  logic [CFG_W-1:0] csr_write_data
);

   localparam logic [RATIO_W-1:0] RATIO_TOP = RATIO_W'(21 * (2 ** RATIO_FRAC_BITS));

   logic [CFG_W-1:0]  min_contrast_ff;
   queue_status_type  queue_status;
   logic              push;
   luma_pair_type     push_data;
   luma_pair_type     pop_data;
   logic              div_valid;
   logic [QUOT_W-1:0] div_quot;
   logic [LUMA_W-1:0] div_text_luma;
   logic [LUMA_W-1:0] div_back_luma;
   logic [QUOT_W:0]   round_sum;
   logic [QUOT_W-1:0] round_quot;
   logic [RATIO_W-1:0] ratio;
   logic              rsp_strobe_ff;
   rsp_payload_type   rsp_payload_ff;
   rsp_payload_type   rsp_payload_in;

   // Hold the accessibility threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         min_contrast_ff <= MIN_CONTRAST_RESET;
      end else if (csr_write_enable) begin
         min_contrast_ff <= csr_write_data;
      end
   end

   cpcc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   cpcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (!queue_status.empty),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   cpcc_divider u_divider (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (!queue_status.empty),
      .in_data       (pop_data),
      .out_valid     (div_valid),
      .out_quot      (div_quot),
      .out_text_luma (div_text_luma),
      .out_back_luma (div_back_luma)
   );

   // Round off the extra quotient bit, saturate, compare with the threshold
   always_comb begin
      round_sum  = (QUOT_W + 1)'(div_quot) + 1'b1;
      round_quot = round_sum[QUOT_W:1];
      ratio      = (round_quot > QUOT_W'(RATIO_MAX)) ? RATIO_MAX : round_quot[RATIO_W-1:0];
      rsp_payload_in.contrast_ratio = ratio;
      rsp_payload_in.accessible     = (CFG_W'(ratio) >= min_contrast_ff);
      rsp_payload_in.text_luminance = div_text_luma;
      rsp_payload_in.back_luminance = div_back_luma;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // The divider drains the queue every cycle, so it never fills
   a_queue_not_full: assert property (@(posedge clock) disable iff (reset)
      !queue_status.full)
      else $error("request queue filled up");

   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.contrast_ratio >= RATIO_ONE &&
                      rsp_payload.contrast_ratio <= RATIO_TOP))
      else $error("contrast ratio outside 1 to 21");

   a_equal_luma_unity: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.text_luminance == rsp_payload.back_luminance)
      |-> rsp_payload.contrast_ratio == RATIO_ONE)
      else $error("equal luminances did not give a ratio of one");
`endif

endmodule

[src/cpcc_front.sv]
// ----------------------------------------------------------------------------
// cpcc_front: request intake and luminance front end
// Linearizes both colors, forms their luminances, orders them into the
// brighter and darker value with the flare offset, and hands them to the queue.
// ----------------------------------------------------------------------------
module cpcc_front
   import cpcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_payload_type  req_payload,
   input  queue_status_type queue_status,
   output logic             push,
   output luma_pair_type    push_data
);

   localparam int STAGES   = 6;
   localparam int CHANNELS = 6;
   localparam int COLORS   = 2;

   logic                    advance;
   logic [STAGES-1:0]       valid_ff;
   logic [STAGES-1:0]       valid_in;

   req_payload_type         color_ff;
   logic [COLOR_W-1:0]      code [CHANNELS];
   logic [LUMA_W-1:0]       lin_ff [CHANNELS];
   logic [LUMA_W-1:0]       lin_in [CHANNELS];
   logic [PROD_W-1:0]       prod_ff [CHANNELS];
   logic [PROD_W-1:0]       prod_in [CHANNELS];
   logic [SUM_W-1:0]        sum_ff [COLORS];
   logic [SUM_W-1:0]        sum_in [COLORS];
   logic [RECIP_PROD_W-1:0] recip_ff [COLORS];
   logic [RECIP_PROD_W-1:0] recip_in [COLORS];
   logic [LUMA_W-1:0]       luma [COLORS];
   logic [ACC_W-1:0]        acc [COLORS];
   luma_pair_type           out_ff;
   luma_pair_type           out_in;

   // Freeze the whole front end while the queue is full
   assign advance  = !queue_status.full;
   assign busy     = queue_status.full;
   assign valid_in = {valid_ff[STAGES-2:0], start & advance};
   assign push     = valid_ff[STAGES-1] & advance;
   assign push_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Channel order: text red, green, blue, then background red, green, blue
   assign code[0] = color_ff.text_red;
   assign code[1] = color_ff.text_green;
   assign code[2] = color_ff.text_blue;
   assign code[3] = color_ff.back_red;
   assign code[4] = color_ff.back_green;
   assign code[5] = color_ff.back_blue;

   // Look up linear light and weight each channel
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         lin_in[ch]  = LIN_LUT[code[ch]];
         prod_in[ch] = PROD_W'(lin_ff[ch]) * PROD_W'(CHANNEL_WEIGHT[ch % 3]);
      end
   end

   // Sum weighted channels, then scale down by the weight total
   always_comb begin
      for (int col = 0; col < COLORS; col++) begin
         acc[col] = ACC_W'(prod_ff[3 * col]) + ACC_W'(prod_ff[3 * col + 1])
                  + ACC_W'(prod_ff[3 * col + 2]) + ACC_W'(SUM_ROUND);
         sum_in[col]   = acc[col][SUM_W-1:0];
         recip_in[col] = RECIP_PROD_W'(sum_ff[col]) * RECIP_PROD_W'(RECIP_MULT);
         luma[col]     = recip_ff[col][RECIP_SHIFT +: LUMA_W];
      end
   end

   // Classify: order the pair and add the flare offset
   always_comb begin
      out_in.text_luma = luma[0];
      out_in.back_luma = luma[1];
      if (luma[0] > luma[1]) begin
         out_in.bright = luma[0] + LUMA_OFFSET;
         out_in.dark   = luma[1] + LUMA_OFFSET;
      end else begin
         out_in.bright = luma[1] + LUMA_OFFSET;
         out_in.dark   = luma[0] + LUMA_OFFSET;
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff <= req_payload;
         lin_ff   <= lin_in;
         prod_ff  <= prod_in;
         sum_ff   <= sum_in;
         recip_ff <= recip_in;
         out_ff   <= out_in;
      end
   end

endmodule

[src/cpcc_queue.sv]
// ----------------------------------------------------------------------------
// cpcc_queue: request queue between front end and divider
// Small circular buffer of classified luminance pairs.
// ----------------------------------------------------------------------------
module cpcc_queue
   import cpcc_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  luma_pair_type    push_data,
   input  logic             pop,
   output luma_pair_type    pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   luma_pair_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & !status.full;
   assign do_pop       = pop & !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/cpcc_divider.sv]
// ----------------------------------------------------------------------------
// cpcc_divider: pipelined ratio divider
// Restoring division of the brighter value, scaled by the ratio fraction
// plus one rounding bit, by the darker value; one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpcc_divider
   import cpcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  luma_pair_type     in_data,
   output logic              out_valid,
   output logic [QUOT_W-1:0] out_quot,
   output logic [LUMA_W-1:0] out_text_luma,
   output logic [LUMA_W-1:0] out_back_luma
);

   logic                  valid_ff [QUOT_W];
   logic [DIVIDEND_W-1:0] rem_ff   [QUOT_W];
   logic [LUMA_W-1:0]     div_ff   [QUOT_W];
   logic [QUOT_W-1:0]     quot_ff  [QUOT_W];
   logic [LUMA_W-1:0]     text_ff  [QUOT_W];
   logic [LUMA_W-1:0]     back_ff  [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - k;

      logic                  prev_valid;
      logic [DIVIDEND_W-1:0] prev_rem;
      logic [LUMA_W-1:0]     prev_div;
      logic [QUOT_W-1:0]     prev_quot;
      logic [LUMA_W-1:0]     prev_text;
      logic [LUMA_W-1:0]     prev_back;
      logic [TRIAL_W-1:0]    trial;
      logic [QUOT_W-1:0]     quot_next;

      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = {in_data.bright, {(RATIO_FRAC_BITS + 1){1'b0}}};
         assign prev_div   = in_data.dark;
         assign prev_quot  = '0;
         assign prev_text  = in_data.text_luma;
         assign prev_back  = in_data.back_luma;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_div   = div_ff[k-1];
         assign prev_quot  = quot_ff[k-1];
         assign prev_text  = text_ff[k-1];
         assign prev_back  = back_ff[k-1];
      end

      // Try subtracting the shifted divisor; keep it when non-negative
      assign trial = TRIAL_W'(prev_rem) - (TRIAL_W'(prev_div) << BIT);

      always_comb begin
         quot_next      = prev_quot;
         quot_next[BIT] = !trial[TRIAL_W-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= trial[TRIAL_W-1] ? prev_rem : trial[DIVIDEND_W-1:0];
         div_ff[k]  <= prev_div;
         quot_ff[k] <= quot_next;
         text_ff[k] <= prev_text;
         back_ff[k] <= prev_back;
      end
   end

   assign out_valid     = valid_ff[QUOT_W-1];
   assign out_quot      = quot_ff[QUOT_W-1];
   assign out_text_luma = text_ff[QUOT_W-1];
   assign out_back_luma = back_ff[QUOT_W-1];

endmodule
